/* src/multicore_job_dispatcher_unit_assert.svh */
// Assertion macros shared by the dispatcher checker.
`ifndef MULTICORE_JOB_DISPATCHER_UNIT_ASSERT_SVH
`define MULTICORE_JOB_DISPATCHER_UNIT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define MJD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MJD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mjd_pkg.sv */
`default_nettype none

package mjd_pkg;

   localparam int CORES_DEF  = 8;
   localparam int QDEPTH_DEF = 16;

   // scheduling schemes
   localparam logic [2:0] SCH_FCFS = 3'd0;
   localparam logic [2:0] SCH_SJF  = 3'd1;
   localparam logic [2:0] SCH_PSJF = 3'd2;
   localparam logic [2:0] SCH_PRI  = 3'd3;
   localparam logic [2:0] SCH_PPRI = 3'd4;
   localparam logic [2:0] SCH_RR   = 3'd5;

   // event codes
   localparam logic [1:0] FN_NEW = 2'd0;
   localparam logic [1:0] FN_FIN = 2'd1;
   localparam logic [1:0] FN_QUA = 2'd2;

   // register map
   localparam int         CSR_IDX_W  = 1;
   localparam int         CSR_DATA_W = 4;
   localparam logic [0:0] CSR_SCHEME = 1'b0;
   localparam logic [0:0] CSR_CORES  = 1'b1;

   localparam logic [3:0]  NO_CORE = 4'hF;
   localparam logic [16:0] NO_JOB  = 17'h1FFFF;

   typedef struct packed {
      logic [15:0] job;
      logic [31:0] arrival;
      logic [15:0] remaining;
      logic [15:0] prio;
      logic        resp_ok;
      logic [31:0] response;
      logic [31:0] waited;
      logic [31:0] enq;
   } qentry_type;

   typedef struct packed {
      logic [15:0] job;
      logic [31:0] arrival;
      logic [15:0] remaining;
      logic [15:0] prio;
      logic [31:0] last;
      logic [31:0] response;
      logic [31:0] waited;
   } core_type;

   typedef struct packed {
      logic       insert;
      logic       pop;
      logic [2:0] scheme;
   } qctl_type;

   // true if job a must be placed strictly before job b
   function automatic logic ahead(input logic [2:0] scheme,
                                  input logic [31:0] arr_a, input logic [15:0] rem_a,
                                  input logic [15:0] pri_a,
                                  input logic [31:0] arr_b, input logic [15:0] rem_b,
                                  input logic [15:0] pri_b);
      logic r;
      unique case (scheme)
         SCH_RR:            r = 1'b0;
         SCH_SJF, SCH_PSJF: r = (rem_a < rem_b) || (rem_a == rem_b && arr_a < arr_b);
         SCH_PRI, SCH_PPRI: r = (pri_a < pri_b) || (pri_a == pri_b && arr_a < arr_b);
         default:           r = arr_a < arr_b;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

`default_nettype wire

/* src/mjd_qcell.sv */
`default_nettype none

module mjd_qcell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mjd_pkg::qctl_type  ctl,
   input  wire mjd_pkg::qentry_type new_entry,
   input  wire mjd_pkg::qentry_type left_entry,
   input  wire logic               left_valid,
   input  wire mjd_pkg::qentry_type right_entry,
   input  wire logic               right_valid,
   input  wire logic               found_in,
   output mjd_pkg::qentry_type     entry,
   output logic                    valid,
   output logic                    found_out
);

   mjd_pkg::qentry_type entry_ff;
   logic                valid_ff;
   logic                flag;

   // new item goes here or before if this slot is empty or it beats the holder
   assign flag = !valid_ff || mjd_pkg::ahead(ctl.scheme, new_entry.arrival,
         new_entry.remaining, new_entry.prio, entry_ff.arrival, entry_ff.remaining,
         entry_ff.prio);
   assign found_out = found_in | flag;

   assign entry = entry_ff;
   assign valid = valid_ff;

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.pop) begin
         valid_ff <= right_valid;
      end else if (ctl.insert) begin
         if (found_in) begin
            valid_ff <= left_valid;
         end else if (flag) begin
            valid_ff <= 1'b1;
         end
      end
   end

   // payload: shift towards the head on pop, away from it behind an insert
   always_ff @(posedge clock) begin
      if (ctl.pop) begin
         entry_ff <= right_entry;
      end else if (ctl.insert) begin
         if (found_in) begin
            entry_ff <= left_entry;
         end else if (flag) begin
            entry_ff <= new_entry;
         end
      end
   end

endmodule

`default_nettype wire

/* src/mjd_queue.sv */
`default_nettype none

module mjd_queue #(
   parameter int DEPTH = mjd_pkg::QDEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mjd_pkg::qctl_type   ctl,
   input  wire mjd_pkg::qentry_type new_entry,
   output mjd_pkg::qentry_type      head,
   output logic                     head_valid,
   output logic                     full
);

   mjd_pkg::qentry_type entries [DEPTH];
   logic [DEPTH-1:0]    valids;
   logic [DEPTH:0]      found;

   assign found[0] = 1'b0;

   // chain of sorted slots, head at slot zero
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      mjd_pkg::qentry_type l_e, r_e;
      logic                l_v, r_v;
      if (i == 0) begin : g_first
         assign l_e = new_entry;
         assign l_v = 1'b0;
      end else begin : g_mid
         assign l_e = entries[i-1];
         assign l_v = valids[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign r_e = new_entry;
         assign r_v = 1'b0;
      end else begin : g_inner
         assign r_e = entries[i+1];
         assign r_v = valids[i+1];
      end
      mjd_qcell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_entry   (new_entry),
         .left_entry  (l_e),
         .left_valid  (l_v),
         .right_entry (r_e),
         .right_valid (r_v),
         .found_in    (found[i]),
         .entry       (entries[i]),
         .valid       (valids[i]),
         .found_out   (found[i+1])
      );
   end

   assign head       = entries[0];
   assign head_valid = valids[0];
   assign full       = valids[DEPTH-1];

endmodule

`default_nettype wire

/* src/multicore_job_dispatcher_unit.sv */
// Job dispatcher for a group of cores.
// Request channel (req_*, valid/ready) carries one event per transaction: a new
// job, a job finished on a core, or a quantum expiry on a core. The response
// channel (rsp_*, valid/ready) returns exactly one result per request: the core
// given to a new job, the job now running on the named core, the drop flag and
// the running totals of wait, turnaround and response time and the job count.
// The csr_* port writes the scheme (index 0) and the active core count (index 1).
// The user must write it only while no transaction is in flight; the block itself
// does not enforce this. A request is worked through the steps of the sequencer in
// order: time advance of the core table, decision, queue insert into the chain of
// queue slots (only when the ready queue takes an insert), result register. One
// transaction is worked at a time, so a new request is taken only after the result
// of the last one is loaded into the output register.
// When the receiver stalls, the result is held in the output register and the
// next request is not finished until it is taken.
// Reset empties the queue, idles all cores, clears the totals, selects
// first-come-first-served and one active core.
`default_nettype none

module multicore_job_dispatcher_unit #(
   parameter int CORES       = mjd_pkg::CORES_DEF,
   parameter int QUEUE_DEPTH = mjd_pkg::QDEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_func,
   input  wire logic [15:0]                    req_job_id,
   input  wire logic [31:0]                    req_now,
   input  wire logic [15:0]                    req_run_time,
   input  wire logic [15:0]                    req_priority_req,
   input  wire logic [2:0]                     req_core_id,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [3:0]                   rsp_assigned_core,
   output logic signed [16:0]                  rsp_next_job,
   output logic                                rsp_dropped,
   output logic [31:0]                         rsp_total_wait,
   output logic [31:0]                         rsp_total_turnaround,
   output logic [31:0]                         rsp_total_response,
   output logic [31:0]                         rsp_completed_count,
   input  wire logic                           csr_we,
   input  wire logic [mjd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mjd_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ADV  = 3'd1;
   localparam logic [2:0] ST_DEC  = 3'd2;
   localparam logic [2:0] ST_INS  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  scheme_ff;
   logic [3:0]  act_ff;

   logic [1:0]  func_ff;
   logic [15:0] job_ff;
   logic [31:0] now_ff;
   logic [15:0] rt_ff;
   logic [15:0] pr_ff;
   logic [2:0]  cid_ff;

   mjd_pkg::core_type   core_ff [CORES];
   logic [CORES-1:0]    busy_ff;
   mjd_pkg::qentry_type ins_ff, ins_in;

   logic [31:0] sum_wait_ff, sum_turn_ff, sum_resp_ff, done_ff;
   logic [3:0]  res_acore_ff, res_acore_in;
   logic [16:0] res_nj_ff, res_nj_in;
   logic        res_drop_ff, res_drop_in;

   logic        rsp_valid_ff;
   logic [3:0]  rsp_acore_ff;
   logic [16:0] rsp_nj_ff;
   logic        rsp_drop_ff;
   logic [31:0] rsp_wait_ff, rsp_turn_ff, rsp_resp_ff, rsp_done_ff;

   logic [CORES-1:0]    in_use, hit, free, beat;
   logic                free_any, beat_any, cur_busy, swap, preempt, sums_upd, load_rsp;
   logic                adv_en;
   logic [CW-1:0]       free_idx, beat_idx;
   logic [15:0]         adv_rem [CORES];
   mjd_pkg::core_type   cur, beaten, start_d, disp_d, core_wd;
   logic [CORES-1:0]    core_we, busy_set, busy_clr;
   mjd_pkg::qctl_type   qctl;
   mjd_pkg::qentry_type q_head;
   logic                q_nonempty, q_full, q_pop;
   logic [31:0]         elapsed [CORES];

   mjd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctl        (qctl),
      .new_entry  (ins_ff),
      .head       (q_head),
      .head_valid (q_nonempty),
      .full       (q_full)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign qctl      = '{insert: (state_ff == ST_INS), pop: q_pop, scheme: scheme_ff};

   // age running jobs only for the three defined events
   assign adv_en = (state_ff == ST_ADV) && ((func_ff == mjd_pkg::FN_NEW) ||
         (func_ff == mjd_pkg::FN_FIN) || (func_ff == mjd_pkg::FN_QUA));

   // core table views: in-use mask, time advance, selections
   always_comb begin
      free_idx = '0;
      beat_idx = '0;
      cur      = '0;
      for (int c = 0; c < CORES; c++) begin
         in_use[c]  = (act_ff == 4'd0) ? (c == 0) : (32'(c) < 32'(act_ff));
         hit[c]     = in_use[c] && (32'(c) == 32'(cid_ff));
         free[c]    = in_use[c] && !busy_ff[c];
         beat[c]    = in_use[c] && mjd_pkg::ahead(scheme_ff, now_ff, rt_ff, pr_ff,
               core_ff[c].arrival, core_ff[c].remaining, core_ff[c].prio);
         elapsed[c] = now_ff - core_ff[c].last;
         adv_rem[c] = (elapsed[c] >= {16'd0, core_ff[c].remaining}) ? 16'd0 :
               core_ff[c].remaining - elapsed[c][15:0];
         if (hit[c]) begin
            cur = core_ff[c];
         end
      end
      for (int c = CORES - 1; c >= 0; c--) begin
         if (free[c]) begin
            free_idx = CW'(c);
         end
         if (beat[c]) begin
            beat_idx = CW'(c);
         end
      end
      free_any = |free;
      beat_any = |beat;
      cur_busy = |(hit & busy_ff);
      beaten   = core_ff[beat_idx];
      preempt  = (scheme_ff == mjd_pkg::SCH_PSJF) || (scheme_ff == mjd_pkg::SCH_PPRI);
      swap     = cur_busy && q_nonempty && !mjd_pkg::ahead(scheme_ff, cur.arrival,
            cur.remaining, cur.prio, q_head.arrival, q_head.remaining, q_head.prio);
   end

   // core loads for a fresh job and for the queue head
   always_comb begin
      start_d = '{job: job_ff, arrival: now_ff, remaining: rt_ff, prio: pr_ff,
                  last: now_ff, response: 32'd1, waited: 32'd0};
      disp_d  = '{job: q_head.job, arrival: q_head.arrival, remaining: q_head.remaining,
                  prio: q_head.prio, last: now_ff,
                  response: q_head.resp_ok ? q_head.response :
                        (now_ff + 32'd1) - q_head.arrival,
                  waited: mjd_pkg::sat_add(q_head.waited, now_ff - q_head.enq)};
   end

   // decision step
   always_comb begin
      state_in     = state_ff;
      core_we      = '0;
      busy_set     = '0;
      busy_clr     = '0;
      core_wd      = start_d;
      q_pop        = 1'b0;
      ins_in       = ins_ff;
      sums_upd     = 1'b0;
      res_acore_in = res_acore_ff;
      res_nj_in    = res_nj_ff;
      res_drop_in  = res_drop_ff;
      load_rsp     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in     = ST_ADV;
               res_acore_in = mjd_pkg::NO_CORE;
               res_nj_in    = mjd_pkg::NO_JOB;
               res_drop_in  = 1'b0;
            end
         end
         ST_ADV: begin
            state_in = ST_DEC;
         end
         ST_DEC: begin
            state_in = ST_DONE;
            unique case (func_ff)
               mjd_pkg::FN_NEW: begin
                  if (free_any) begin
                     core_we[free_idx]  = 1'b1;
                     busy_set[free_idx] = 1'b1;
                     res_acore_in       = 4'(free_idx);
                  end else if (q_full) begin
                     res_drop_in = 1'b1;
                  end else if (preempt && beat_any) begin
                     core_we[beat_idx] = 1'b1;
                     res_acore_in      = 4'(beat_idx);
                     ins_in = '{job: beaten.job, arrival: beaten.arrival,
                                remaining: beaten.remaining, prio: beaten.prio,
                                resp_ok: 1'b1, response: beaten.response,
                                waited: beaten.waited, enq: now_ff};
                     state_in = ST_INS;
                  end else begin
                     ins_in = '{job: job_ff, arrival: now_ff, remaining: rt_ff,
                                prio: pr_ff, resp_ok: 1'b0, response: 32'd0,
                                waited: 32'd0, enq: now_ff};
                     state_in = ST_INS;
                  end
               end
               mjd_pkg::FN_FIN: begin
                  if (cur_busy) begin
                     sums_upd = 1'b1;
                     if (q_nonempty) begin
                        core_we   = hit;
                        core_wd   = disp_d;
                        q_pop     = 1'b1;
                        res_nj_in = {1'b0, q_head.job};
                     end else begin
                        busy_clr = hit;
                     end
                  end
               end
               mjd_pkg::FN_QUA: begin
                  if (cur_busy) begin
                     if (swap) begin
                        ins_in = '{job: cur.job, arrival: cur.arrival,
                                   remaining: cur.remaining, prio: cur.prio,
                                   resp_ok: 1'b1, response: cur.response,
                                   waited: cur.waited, enq: now_ff};
                        core_we   = hit;
                        core_wd   = disp_d;
                        q_pop     = 1'b1;
                        res_nj_in = {1'b0, q_head.job};
                        state_in  = ST_INS;
                     end else begin
                        res_nj_in = {1'b0, cur.job};
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_INS: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state, configuration, totals
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scheme_ff    <= mjd_pkg::SCH_FCFS;
         act_ff       <= 4'd1;
         busy_ff      <= '0;
         sum_wait_ff  <= '0;
         sum_turn_ff  <= '0;
         sum_resp_ff  <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (busy_ff | busy_set) & ~busy_clr;
         rsp_valid_ff <= (rsp_valid_ff && !rsp_ready) || load_rsp;
         if (csr_we) begin
            unique case (csr_index)
               mjd_pkg::CSR_SCHEME: scheme_ff <= csr_wdata[2:0];
               mjd_pkg::CSR_CORES:  act_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (sums_upd) begin
            done_ff     <= mjd_pkg::sat_add(done_ff, 32'd1);
            sum_turn_ff <= mjd_pkg::sat_add(sum_turn_ff, now_ff - cur.arrival);
            sum_wait_ff <= mjd_pkg::sat_add(sum_wait_ff, cur.waited);
            sum_resp_ff <= mjd_pkg::sat_add(sum_resp_ff, cur.response);
         end
      end
   end

   // captured request, core table payload, results
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff <= req_func;
         job_ff  <= req_job_id;
         now_ff  <= req_now;
         rt_ff   <= req_run_time;
         pr_ff   <= req_priority_req;
         cid_ff  <= req_core_id;
      end
      ins_ff       <= ins_in;
      res_acore_ff <= res_acore_in;
      res_nj_ff    <= res_nj_in;
      res_drop_ff  <= res_drop_in;
      for (int c = 0; c < CORES; c++) begin
         if (adv_en && busy_ff[c] && in_use[c]) begin
            core_ff[c].remaining <= adv_rem[c];
            core_ff[c].last      <= now_ff;
         end else if (core_we[c]) begin
            core_ff[c] <= core_wd;
         end
      end
      if (load_rsp) begin
         rsp_acore_ff <= res_acore_ff;
         rsp_nj_ff    <= res_nj_ff;
         rsp_drop_ff  <= res_drop_ff;
         rsp_wait_ff  <= sum_wait_ff;
         rsp_turn_ff  <= sum_turn_ff;
         rsp_resp_ff  <= sum_resp_ff;
         rsp_done_ff  <= done_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_assigned_core    = rsp_acore_ff;
   assign rsp_next_job         = rsp_nj_ff;
   assign rsp_dropped          = rsp_drop_ff;
   assign rsp_total_wait       = rsp_wait_ff;
   assign rsp_total_turnaround = rsp_turn_ff;
   assign rsp_total_response   = rsp_resp_ff;
   assign rsp_completed_count  = rsp_done_ff;

endmodule

`default_nettype wire

/* src/mjd_checker.sv */
`default_nettype none

`include "multicore_job_dispatcher_unit_assert.svh"

module mjd_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic signed [3:0]              rsp_assigned_core,
   input wire logic signed [16:0]             rsp_next_job,
   input wire logic                           rsp_dropped
);

   // a pending result stays up until taken
   `MJD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // one transaction at a time: no request taken on the cycle after one
   `MJD_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

   // a result never names both a core and a job
   `MJD_ASSERT_ALWAYS(a_core_or_job, !rsp_valid || rsp_assigned_core == -4'sd1 || rsp_next_job == -17'sd1, "core and job both reported")

   // a dropped job is never placed on a core
   `MJD_ASSERT_ALWAYS(a_drop_no_core, !(rsp_valid && rsp_dropped) || rsp_assigned_core == -4'sd1, "dropped job given a core")

endmodule

bind multicore_job_dispatcher_unit mjd_checker u_mjd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_assigned_core (rsp_assigned_core),
   .rsp_next_job      (rsp_next_job),
   .rsp_dropped       (rsp_dropped)
);

`default_nettype wire
